>>> src/plcm_pkg.sv
// ============================================================================
// plcm_pkg
// Shared types and constants of the piecewise-linear colormap pipeline.
// ============================================================================
package plcm_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 17;
    localparam int COLOR_W = 8;
    localparam int RGBA_W  = 4 * COLOR_W;
    localparam int SPAN_W  = VALUE_W + 1;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] CFG_CLAMP_HIGH = 2'd1;
    localparam logic [1:0] CFG_CAT_MODE   = 2'd2;
    localparam logic [1:0] CFG_STOP_COUNT = 2'd3;

    localparam logic ACTION_LOOKUP = 1'b0;
    localparam logic ACTION_WRITE  = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] range_low;
        logic signed [VALUE_W-1:0] clamp_high;
        logic                      cat;
        logic [3:0]                count;
    } t_cfg;

    // Color word packs red in the lowest byte, then green, blue and alpha.
    typedef struct packed {
        logic              is_write;
        logic              cat;
        logic              err;
        logic              sat_lo;
        logic              sat_hi;
        logic [7:0]        opacity;
        logic [2:0]        idx;
        logic [POS_W-1:0]  pos;
        logic [RGBA_W-1:0] rgba;
    } t_side;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [RGBA_W-1:0] rgba;
    } t_stop;

endpackage

>>> src/plcm_norm.sv
// ============================================================================
// plcm_norm
// Offset and span stages followed by a pipelined restoring divider that
// produces the normalized position, or the categorical index as a remainder.
// ============================================================================
module plcm_norm #(
    parameter int FRAC_BITS = 16,
    parameter int CW        = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  plcm_pkg::t_side              i_side,
    input  logic [plcm_pkg::VALUE_W-1:0] i_value,
    input  plcm_pkg::t_cfg               i_cfg,
    input  logic [CW-1:0]                i_count,
    output logic                         o_valid,
    output plcm_pkg::t_side              o_side,
    output logic [plcm_pkg::POS_W-1:0]   o_n,
    output logic [plcm_pkg::SPAN_W-1:0]  o_rem
);
    import plcm_pkg::*;

    localparam int NS_A = ((33 - FRAC_BITS) > POS_W) ? (33 - FRAC_BITS) : POS_W;
    localparam int NS   = ((FRAC_BITS + 1) > NS_A) ? (FRAC_BITS + 1) : NS_A;
    localparam int SH   = NS - FRAC_BITS;
    localparam int NW   = SPAN_W + FRAC_BITS;
    localparam int OW   = SPAN_W + SH;
    localparam int IPW  = SPAN_W - FRAC_BITS;

    logic                     r_a_valid;
    t_side                    r_a_side;
    logic signed [SPAN_W-1:0] r_a_diff;
    logic signed [SPAN_W-1:0] r_a_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
        end
        if (i_adv) begin
            r_a_side <= i_side;
            r_a_diff <= {i_value[VALUE_W-1], i_value}
                        - {i_cfg.range_low[VALUE_W-1], i_cfg.range_low};
            r_a_span <= {i_cfg.clamp_high[VALUE_W-1], i_cfg.clamp_high}
                        - {i_cfg.range_low[VALUE_W-1], i_cfg.range_low};
        end
    end

    logic [SPAN_W-1:0] abs_d;
    logic [SPAN_W-1:0] abs_s;
    logic [NW-1:0]     num;
    logic [IPW-1:0]    ip;
    logic              ovf;
    t_side             b_side;

    always_comb begin
        abs_d  = r_a_diff[SPAN_W-1] ? SPAN_W'(-r_a_diff) : SPAN_W'(r_a_diff);
        abs_s  = r_a_span[SPAN_W-1] ? SPAN_W'(-r_a_span) : SPAN_W'(r_a_span);
        num    = {abs_d, {FRAC_BITS{1'b0}}};
        ip     = r_a_diff[SPAN_W-1] ? '0 : r_a_diff[SPAN_W-1:FRAC_BITS];
        ovf    = {{SH{1'b0}}, abs_d} >= OW'({abs_s, {SH{1'b0}}});
        b_side = r_a_side;
        b_side.err    = !r_a_side.cat && (r_a_span == '0);
        b_side.sat_lo = r_a_diff[SPAN_W-1] != r_a_span[SPAN_W-1];
        b_side.sat_hi = ovf;
    end

    logic              r_valid [NS+1];
    t_side             r_side  [NS+1];
    logic [SPAN_W-1:0] r_rem   [NS+1];
    logic [SPAN_W-1:0] r_div   [NS+1];
    logic [NS-1:0]     r_bits  [NS+1];
    logic [NS-1:0]     r_quo   [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_adv) begin
            r_valid[0] <= r_a_valid;
        end
        if (i_adv) begin
            r_side[0] <= b_side;
            r_quo[0]  <= '0;
            if (r_a_side.cat) begin
                r_rem[0]  <= '0;
                r_bits[0] <= NS'(ip);
                r_div[0]  <= SPAN_W'(i_count);
            end else begin
                r_rem[0]  <= SPAN_W'(num[NW-1:NS]);
                r_bits[0] <= num[NS-1:0];
                r_div[0]  <= abs_s;
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [SPAN_W:0]   trial;
        logic              ge;
        logic [SPAN_W-1:0] n_rem;

        always_comb begin
            trial = {r_rem[k], r_bits[k][NS-1]};
            ge    = trial >= {1'b0, r_div[k]};
            n_rem = ge ? SPAN_W'(trial - {1'b0, r_div[k]}) : trial[SPAN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (i_adv) begin
                r_side[k+1] <= r_side[k];
                r_rem[k+1]  <= n_rem;
                r_div[k+1]  <= r_div[k];
                r_bits[k+1] <= {r_bits[k][NS-2:0], 1'b0};
                r_quo[k+1]  <= {r_quo[k][NS-2:0], ge};
            end
        end
    end

    always_comb begin
        o_valid = r_valid[NS];
        o_side  = r_side[NS];
        o_rem   = r_rem[NS];
        if (r_side[NS].sat_lo) begin
            o_n = '0;
        end else if (r_side[NS].sat_hi || (r_quo[NS] > NS'(POS_MAX))) begin
            o_n = POS_MAX;
        end else begin
            o_n = r_quo[NS][POS_W-1:0];
        end
    end

endmodule

>>> src/plcm_lookup.sv
// ============================================================================
// plcm_lookup
// Stop table with position compare, stop search and registered color reads.
// Stop writes take effect in pipeline order at this stage.
// ============================================================================
module plcm_lookup #(
    parameter int MAX_STOPS = 8,
    parameter int SIW       = 3,
    parameter int CW        = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  plcm_pkg::t_side             i_side,
    input  logic [plcm_pkg::POS_W-1:0]  i_n,
    input  logic [plcm_pkg::SPAN_W-1:0] i_rem,
    input  logic [CW-1:0]               i_count,
    output logic                        o_valid,
    output plcm_pkg::t_side             o_side,
    output logic [plcm_pkg::POS_W-1:0]  o_n,
    output logic                        o_found,
    output logic                        o_has_lo,
    output plcm_pkg::t_stop             o_hi,
    output plcm_pkg::t_stop             o_lo
);
    import plcm_pkg::*;

    logic [POS_W-1:0] r_pos [MAX_STOPS];
    t_stop            r_mem [MAX_STOPS];

    logic [MAX_STOPS-1:0] gt;
    logic [SIW-1:0]       first;
    logic                 found;
    logic [SIW-1:0]       hi_addr;
    logic [SIW-1:0]       lo_addr;
    logic [SIW-1:0]       wr_addr;
    logic                 wr_en;

    always_comb begin
        for (int i = 0; i < MAX_STOPS; i++) begin
            gt[i] = (CW'(i) < i_count) && (r_pos[i] > i_n);
        end
        first = '0;
        for (int i = MAX_STOPS - 1; i >= 0; i--) begin
            if (gt[i]) begin
                first = SIW'(i);
            end
        end
        found = |gt;
        if (i_side.cat) begin
            hi_addr = i_rem[SIW-1:0];
        end else if (found) begin
            hi_addr = first;
        end else begin
            hi_addr = SIW'(i_count - 1'b1);
        end
        lo_addr = first - 1'b1;
        wr_addr = SIW'(i_side.idx);
        wr_en   = i_adv && i_valid && i_side.is_write && (int'(i_side.idx) < MAX_STOPS);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pos[wr_addr] <= i_side.pos;
            r_mem[wr_addr] <= {i_side.pos, i_side.rgba};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
        if (i_adv) begin
            o_side   <= i_side;
            o_n      <= i_n;
            o_found  <= found;
            o_has_lo <= found && (first != '0);
            o_hi     <= r_mem[hi_addr];
            o_lo     <= r_mem[lo_addr];
        end
    end

endmodule

>>> src/plcm_blend.sv
// ============================================================================
// plcm_blend
// Blend weights, per-channel products and a pipelined eight-step divider
// that truncates the linear blend; also selects the direct colors.
// ============================================================================
module plcm_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  plcm_pkg::t_side             i_side,
    input  logic [plcm_pkg::POS_W-1:0]  i_n,
    input  logic                        i_found,
    input  logic                        i_has_lo,
    input  plcm_pkg::t_stop             i_hi,
    input  plcm_pkg::t_stop             i_lo,
    output logic                        o_valid,
    output plcm_pkg::t_side             o_side,
    output logic [plcm_pkg::RGBA_W-1:0] o_rgba
);
    import plcm_pkg::*;

    localparam int NUM_W = COLOR_W + POS_W + 1;
    localparam int QB    = COLOR_W;

    logic [POS_W-1:0]  lp;
    logic [RGBA_W-1:0] lc;
    logic [RGBA_W-1:0] direct;
    logic              use_direct;

    always_comb begin
        lp = i_has_lo ? i_lo.pos : '0;
        lc = i_has_lo ? i_lo.rgba : '0;
        use_direct = i_side.err || i_side.cat || !i_found || i_side.is_write;
        if (i_side.err) begin
            direct = '0;
        end else if (i_side.cat) begin
            direct = i_hi.rgba;
        end else begin
            direct = {i_side.opacity, i_hi.rgba[3*COLOR_W-1:0]};
        end
    end

    logic                  r_e_valid;
    t_side                 r_e_side;
    logic [RGBA_W-1:0]     r_e_direct;
    logic                  r_e_use_direct;
    logic [3*COLOR_W-1:0]  r_e_lc;
    logic [3*COLOR_W-1:0]  r_e_hc;
    logic [POS_W-1:0]      r_e_dh;
    logic [POS_W-1:0]      r_e_dl;
    logic [POS_W-1:0]      r_e_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_adv) begin
            r_e_valid <= i_valid;
        end
        if (i_adv) begin
            r_e_side       <= i_side;
            r_e_direct     <= direct;
            r_e_use_direct <= use_direct;
            r_e_lc         <= lc[3*COLOR_W-1:0];
            r_e_hc         <= i_hi.rgba[3*COLOR_W-1:0];
            r_e_dh         <= i_hi.pos - i_n;
            r_e_dl         <= i_n - lp;
            r_e_den        <= i_hi.pos - lp;
        end
    end

    logic              r_valid [QB+1];
    t_side             r_side  [QB+1];
    logic [RGBA_W-1:0] r_direct[QB+1];
    logic              r_use   [QB+1];
    logic [POS_W-1:0]  r_den   [QB+1];
    logic [POS_W-1:0]  r_rem   [QB+1][3];
    logic [QB-1:0]     r_bits  [QB+1][3];
    logic [QB-1:0]     r_quo   [QB+1][3];

    logic [NUM_W-1:0] num [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num[c] = NUM_W'(r_e_lc[c*COLOR_W +: COLOR_W]) * NUM_W'(r_e_dh)
                     + NUM_W'(r_e_hc[c*COLOR_W +: COLOR_W]) * NUM_W'(r_e_dl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_adv) begin
            r_valid[0] <= r_e_valid;
        end
        if (i_adv) begin
            r_side[0]   <= r_e_side;
            r_direct[0] <= r_e_direct;
            r_use[0]    <= r_e_use_direct;
            r_den[0]    <= r_e_den;
            for (int c = 0; c < 3; c++) begin
                r_rem[0][c]  <= num[c][NUM_W-2:QB];
                r_bits[0][c] <= num[c][QB-1:0];
                r_quo[0][c]  <= '0;
            end
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [POS_W:0]   trial [3];
        logic             ge    [3];
        logic [POS_W-1:0] n_rem [3];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                trial[c] = {r_rem[k][c], r_bits[k][c][QB-1]};
                ge[c]    = trial[c] >= {1'b0, r_den[k]};
                n_rem[c] = ge[c] ? POS_W'(trial[c] - {1'b0, r_den[k]})
                                 : trial[c][POS_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (i_adv) begin
                r_side[k+1]   <= r_side[k];
                r_direct[k+1] <= r_direct[k];
                r_use[k+1]    <= r_use[k];
                r_den[k+1]    <= r_den[k];
                for (int c = 0; c < 3; c++) begin
                    r_rem[k+1][c]  <= n_rem[c];
                    r_bits[k+1][c] <= {r_bits[k][c][QB-2:0], 1'b0};
                    r_quo[k+1][c]  <= {r_quo[k][c][QB-2:0], ge[c]};
                end
            end
        end
    end

    always_comb begin
        o_valid = r_valid[QB];
        o_side  = r_side[QB];
        if (r_use[QB]) begin
            o_rgba = r_direct[QB];
        end else begin
            o_rgba = {r_side[QB].opacity, r_quo[QB][2], r_quo[QB][1], r_quo[QB][0]};
        end
    end

endmodule

>>> src/piecewise_linear_colormap_top.sv
// ============================================================================
// piecewise_linear_colormap_top
// Maps signed fixed-point values to RGBA through a table of color stops.
//
// Channel   Direction  Handshake            Payload
// s_axis    in         i_s_tvalid/o_s_tready  tdata: value, opacity, stop fields
//                                             tuser: action
// m_axis    out        o_m_tvalid/i_m_tready  tdata: red, green, blue, alpha
//                                             tuser: range_error
// cfg       in         i_cfg_we               i_cfg_addr, i_cfg_wdata
//
// One request enters every cycle while the output is not stalled. The normalizing
// divider has NS = max(17, 33 - FRAC_BITS, FRAC_BITS + 1) steps and the blend
// divider has eight steps.
// Stop writes produce no result and update the table in pipeline order.
// Reset clears the pipeline valid bits and sets the configuration registers to their defaults.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// ============================================================================
module piecewise_linear_colormap_top #(
    parameter int MAX_STOPS = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // value[31:0], opacity[39:32], stop_index[42:40], stop_position[59:43],
    // stop_red[67:60], stop_green[75:68], stop_blue[83:76], stop_alpha[91:84]
    input  logic [95:0] i_s_tdata,
    // action[0]
    input  logic [0:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic [31:0] o_m_tdata,
    // range_error[0]
    output logic [0:0]  o_m_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);
    import plcm_pkg::*;

    localparam int CW  = $clog2(MAX_STOPS + 1);
    localparam int SIW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low  <= '0;
            r_cfg.clamp_high <= 32'sd65536;
            r_cfg.cat        <= 1'b0;
            r_cfg.count      <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_RANGE_LOW:  r_cfg.range_low  <= i_cfg_wdata;
                CFG_CLAMP_HIGH: r_cfg.clamp_high <= i_cfg_wdata;
                CFG_CAT_MODE:   r_cfg.cat        <= i_cfg_wdata[0];
                CFG_STOP_COUNT: r_cfg.count      <= i_cfg_wdata[3:0];
                default:        r_cfg.count      <= r_cfg.count;
            endcase
        end
    end

    logic [CW-1:0] count;

    always_comb begin
        if (r_cfg.count == '0) begin
            count = CW'(1);
        end else if (int'(r_cfg.count) > MAX_STOPS) begin
            count = CW'(MAX_STOPS);
        end else begin
            count = CW'(r_cfg.count);
        end
    end

    logic        r_out_valid;
    logic [31:0] r_out_rgba;
    logic        r_out_err;
    logic        adv;
    t_side       in_side;

    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = adv;

    always_comb begin
        in_side          = '0;
        in_side.is_write = i_s_tuser[0] == ACTION_WRITE;
        in_side.cat      = r_cfg.cat;
        in_side.opacity  = i_s_tdata[39:32];
        in_side.idx      = i_s_tdata[42:40];
        in_side.pos      = i_s_tdata[59:43];
        in_side.rgba     = i_s_tdata[91:60];
    end

    logic                nm_valid;
    t_side               nm_side;
    logic [POS_W-1:0]    nm_n;
    logic [SPAN_W-1:0]   nm_rem;

    plcm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_s_tvalid),
        .i_side  (in_side),
        .i_value (i_s_tdata[31:0]),
        .i_cfg   (r_cfg),
        .i_count (count),
        .o_valid (nm_valid),
        .o_side  (nm_side),
        .o_n     (nm_n),
        .o_rem   (nm_rem)
    );

    logic             lk_valid;
    t_side            lk_side;
    logic [POS_W-1:0] lk_n;
    logic             lk_found;
    logic             lk_has_lo;
    t_stop            lk_hi;
    t_stop            lk_lo;

    plcm_lookup #(
        .MAX_STOPS (MAX_STOPS),
        .SIW       (SIW),
        .CW        (CW)
    ) u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (nm_valid),
        .i_side   (nm_side),
        .i_n      (nm_n),
        .i_rem    (nm_rem),
        .i_count  (count),
        .o_valid  (lk_valid),
        .o_side   (lk_side),
        .o_n      (lk_n),
        .o_found  (lk_found),
        .o_has_lo (lk_has_lo),
        .o_hi     (lk_hi),
        .o_lo     (lk_lo)
    );

    logic              bl_valid;
    t_side             bl_side;
    logic [RGBA_W-1:0] bl_rgba;

    plcm_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (lk_valid),
        .i_side   (lk_side),
        .i_n      (lk_n),
        .i_found  (lk_found),
        .i_has_lo (lk_has_lo),
        .i_hi     (lk_hi),
        .i_lo     (lk_lo),
        .o_valid  (bl_valid),
        .o_side   (bl_side),
        .o_rgba   (bl_rgba)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= bl_valid && !bl_side.is_write;
        end
        if (adv) begin
            r_out_rgba <= bl_rgba;
            r_out_err  <= bl_side.err;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_rgba;
    assign o_m_tuser[0] = r_out_err;

    a_err_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("range error result carries a nonzero color");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(bl_valid && !bl_side.is_write))
        else $error("result appeared without a lookup leaving the blend stage");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && bl_valid && bl_side.is_write) |=> !o_m_tvalid)
        else $error("stop write produced a result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule
